/* src/exponential_distribution_eval_core_assert.svh */
// ----------------------------------------------------------------------------
// Exponential distribution evaluator assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef EXPONENTIAL_DISTRIBUTION_EVAL_CORE_ASSERT_SVH
`define EXPONENTIAL_DISTRIBUTION_EVAL_CORE_ASSERT_SVH

// checked outside reset only
`define EDIST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define EDIST_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/edist_pkg.sv */
// ----------------------------------------------------------------------------
// Exponential distribution evaluator package
// Shared constants, command and register codes, pipeline payload types.
// ----------------------------------------------------------------------------
package edist_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int REG_BITS   = 31;
  localparam int PROB_BITS  = 16;
  localparam int Q_BITS     = PROB_BITS + 1;
  localparam int CMD_BITS   = 2;
  localparam int IDX_BITS   = 2;

  localparam logic [31:0] LN2_Q32   = 32'd2977044471;
  localparam logic [31:0] LOG2E_Q31 = 32'd3098164010;
  localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
  localparam logic [REG_BITS-1:0] ONE_QF = REG_BITS'(1 << FRAC_BITS);
  localparam logic [4:0]  QM_TOP    = 5'(PROB_BITS);

  localparam int SERIES_TERMS    = 20;
  localparam int DIV_STAGES      = 16;
  localparam int DIV_STEP_BITS   = 2;
  localparam int EXP_PREP_STAGES = 4;
  localparam int XDELAY          = DIV_STAGES + 1 - EXP_PREP_STAGES;

  // exponent at or above the limit underflows to zero
  localparam logic [6:0] N_FLUSH = 7'h7f;
  localparam logic [6:0] N_LIMIT = 7'(64 - FRAC_BITS);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_DENSITY    = 2'd0,
    CMD_CUMULATIVE = 2'd1,
    CMD_QUANTILE   = 2'd2
  } cmd_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_LOWER_BOUND  = 2'd0,
    REG_DECAY_LENGTH = 2'd1,
    REG_DECAY_RATE   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic       valid;
    cmd_t       cmd;
    logic       below;
    logic [4:0] m;
    logic [6:0] n;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic [31:0] op;
    logic [32:0] term;
    logic [32:0] sum;
  } ser_t;

endpackage

/* src/edist_div_pipe.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Quotient of (num << 32) / den with num < den, two bits per stage.
// ----------------------------------------------------------------------------
module edist_div_pipe (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [30:0] num_i,
  input  logic [32:0] den_i,
  output logic [31:0] quo_o
);

  logic [32:0] rem_r [edist_pkg::DIV_STAGES];
  logic [32:0] den_r [edist_pkg::DIV_STAGES];
  logic [31:0] quo_r [edist_pkg::DIV_STAGES];

  for (genvar s = 0; s < edist_pkg::DIV_STAGES; s++) begin : g_stage
    logic [32:0] rem_in;
    logic [32:0] den_in;
    logic [31:0] quo_in;
    logic [32:0] rem_nxt;
    logic [31:0] quo_nxt;

    if (s == 0) begin : g_first
      assign rem_in = {2'b00, num_i};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin : p_step
      logic [33:0] trial;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int b = 0; b < edist_pkg::DIV_STEP_BITS; b++) begin
        trial = {rem_nxt, 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt = 33'(trial - {1'b0, den_in});
          quo_nxt = {quo_nxt[30:0], 1'b1};
        end else begin
          rem_nxt = trial[32:0];
          quo_nxt = {quo_nxt[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rem_r[s] <= '0;
        den_r[s] <= '0;
        quo_r[s] <= '0;
      end else if (en) begin
        rem_r[s] <= rem_nxt;
        den_r[s] <= den_in;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[edist_pkg::DIV_STAGES-1];

endmodule

/* src/edist_series_step.sv */
// ----------------------------------------------------------------------------
// Series step
// One term of the exp or atanh-form log series: multiply, reciprocal
// multiply, remainder correction and accumulate over three stages.
// ----------------------------------------------------------------------------
module edist_series_step #(
  parameter int STEP = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  edist_pkg::ser_t  ser_i,
  output edist_pkg::ser_t  ser_o
);

  localparam logic [5:0]  K_EXP    = 6'(STEP);
  localparam logic [5:0]  K_LN     = 6'(2 * STEP + 1);
  localparam logic [32:0] R_EXP    = 33'((64'd1 << 32) / STEP);
  localparam logic [32:0] R_LN     = 33'((64'd1 << 32) / (2 * STEP + 1));
  localparam bit          SUBTRACT = (STEP % 2) == 1;

  edist_pkg::ser_t a_r, a_nxt;
  edist_pkg::ser_t b_r;
  edist_pkg::ser_t c_r, c_nxt;
  logic [31:0]     q0_r, q0_nxt;

  logic [64:0] prod_a;
  logic [64:0] prod_b;
  logic [32:0] recip;
  logic        ln_b;
  logic        ln_c;
  logic [5:0]  k;
  logic [37:0] qk;
  logic [37:0] rem;
  logic [31:0] q;

  assign prod_a = 65'(ser_i.term) * 65'(ser_i.op);

  always_comb begin
    a_nxt      = ser_i;
    a_nxt.term = {1'b0, prod_a[63:32]};
  end

  assign ln_b   = a_r.tag.cmd == edist_pkg::CMD_QUANTILE;
  assign recip  = ln_b ? R_LN : R_EXP;
  assign prod_b = 65'(a_r.term[31:0]) * 65'(recip);
  assign q0_nxt = prod_b[63:32];

  assign ln_c = b_r.tag.cmd == edist_pkg::CMD_QUANTILE;
  assign k    = ln_c ? K_LN : K_EXP;
  assign qk   = 38'(q0_r) * 38'(k);
  assign rem  = 38'(b_r.term[31:0]) - qk;
  assign q    = q0_r + 32'(rem >= 38'(k));

  always_comb begin
    c_nxt = b_r;
    if (ln_c) begin
      c_nxt.sum = b_r.sum + 33'(q);
    end else begin
      c_nxt.term = {1'b0, q};
      c_nxt.sum  = SUBTRACT ? b_r.sum - 33'(q) : b_r.sum + 33'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r  <= '0;
      b_r  <= '0;
      q0_r <= '0;
      c_r  <= '0;
    end else if (en) begin
      a_r  <= a_nxt;
      b_r  <= a_r;
      q0_r <= q0_nxt;
      c_r  <= c_nxt;
    end
  end

  assign ser_o = c_r;

endmodule

/* src/exponential_distribution_eval_core.sv */
// ----------------------------------------------------------------------------
// Exponential distribution evaluator
// Density, cumulative probability and quantile of a shifted exponential
// distribution in signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes lower_bound, decay_length and decay_rate by index;
//   cfg_ready is always high. Write only while no item is in flight.
//   in channel takes command, sample_point and probability; every item
//   gives one result on the out channel, in order.
//   An item passes the input slice, the 16-stage divider and
//   20 three-stage series steps on its way to out_valid.
//   Throughput: one item per cycle while the skid register is empty; every stage is a register slice.
//   A skid register behind the output register absorbs one result when
//   out_ready drops; in_ready then falls and the whole pipeline holds
//   until the skid empties. Nothing is dropped or repeated.
//   Reset (synchronous, rst_n low) clears all valid bits and restores the
//   register defaults: lower_bound 0, decay_length 1.0, decay_rate 1.0.
// ----------------------------------------------------------------------------
module exponential_distribution_eval_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [edist_pkg::IDX_BITS-1:0]        cfg_index,
  input  logic [edist_pkg::WORD_BITS-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [edist_pkg::CMD_BITS-1:0]        in_command,
  input  logic signed [edist_pkg::WORD_BITS-1:0] in_sample_point,
  input  logic [edist_pkg::PROB_BITS-1:0]       in_probability,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [edist_pkg::WORD_BITS-1:0] out_result_value,
  output logic                                  out_saturated
);

  typedef struct packed {
    edist_pkg::tag_t tag;
    logic [31:0]     y;
  } xd_t;

  logic                en;

  logic signed [31:0]  lower_bound_r;
  logic [30:0]         decay_length_r;
  logic [30:0]         decay_rate_r;

  logic                p1_vld_r;
  edist_pkg::cmd_t     p1_cmd_r;
  logic signed [31:0]  p1_x_r;
  logic [15:0]         p1_p_r;

  edist_pkg::tag_t     tag2_r, tag2_nxt;
  logic [32:0]         diff2;
  logic [31:0]         d2_r;
  logic [16:0]         q2;
  logic [4:0]          m2;
  logic [31:0]         mant2;
  logic [30:0]         a2_r;
  logic [32:0]         den2_r;

  logic [62:0]         tprod;
  edist_pkg::tag_t     tag3_r;
  logic [46:0]         t3_r;

  edist_pkg::tag_t     tag4_r;
  logic                big4_r;
  logic [47:0]         pa4_r;
  logic [37:0]         pb4_r;

  logic [37:0]         v5;
  edist_pkg::tag_t     tag5_r, tag5_nxt;
  logic [30:0]         f5_r;

  logic [62:0]         yprod;
  edist_pkg::tag_t     tag6_r;
  logic [31:0]         y6_r;

  xd_t                 xd_r [edist_pkg::XDELAY];
  xd_t                 xd_nxt;
  xd_t                 xd_out;

  logic [31:0]         quo;
  logic [63:0]         zprod;
  logic [31:0]         zz_z_r;
  logic [31:0]         zz_z2_r;

  edist_pkg::ser_t     ser_c [edist_pkg::SERIES_TERMS+1];
  edist_pkg::ser_t     ser_in;
  edist_pkg::ser_t     ser_end;

  logic [5:0]          sh;
  logic [63:0]         rnd;
  logic [16:0]         e_nxt;
  logic [37:0]         lnpos;
  logic signed [37:0]  lqs;
  logic [35:0]         lq_nxt;
  edist_pkg::tag_t     bk_tag_r;
  logic [16:0]         bk_e_r;
  logic [35:0]         bk_lq_r;

  logic                mu_ln;
  logic [30:0]         ma;
  logic [31:0]         mb;
  edist_pkg::tag_t     mu_tag_r;
  logic [16:0]         mu_e_r;
  logic [62:0]         mu_lo_r;
  logic [34:0]         mu_hi_r;

  logic [62:0]         lo_rnd;
  logic [36:0]         qprod;
  logic signed [37:0]  qtotal;
  logic [31:0]         fin_res;
  logic                fin_sat;
  logic                fin_vld;

  logic                out_vld_r;
  logic [31:0]         out_res_r;
  logic                out_sat_r;
  logic                skid_vld_r;
  logic [31:0]         skid_res_r;
  logic                skid_sat_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r  <= '0;
      decay_length_r <= edist_pkg::ONE_QF;
      decay_rate_r   <= edist_pkg::ONE_QF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        edist_pkg::REG_LOWER_BOUND:  lower_bound_r  <= cfg_data;
        edist_pkg::REG_DECAY_LENGTH: decay_length_r <= cfg_data[30:0];
        edist_pkg::REG_DECAY_RATE:   decay_rate_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign en       = !skid_vld_r;
  assign in_ready = en;

  // input slice
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= in_valid;
      p1_cmd_r <= edist_pkg::cmd_t'(in_command);
      p1_x_r   <= in_sample_point;
      p1_p_r   <= in_probability;
    end
  end

  // offset from the bound, quantile mantissa
  assign diff2 = {p1_x_r[31], p1_x_r} - {lower_bound_r[31], lower_bound_r};
  assign q2    = 17'h1_0000 - 17'(p1_p_r);

  always_comb begin
    m2 = '0;
    for (int i = 0; i < edist_pkg::Q_BITS; i++) begin
      if (q2[i]) m2 = 5'(i);
    end
  end

  assign mant2 = 32'({15'b0, q2} << (5'd31 - m2));

  always_comb begin
    tag2_nxt       = '0;
    tag2_nxt.valid = p1_vld_r;
    tag2_nxt.cmd   = p1_cmd_r;
    tag2_nxt.below = p1_x_r < lower_bound_r;
    tag2_nxt.m     = m2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (en) begin
      tag2_r <= tag2_nxt;
      d2_r   <= diff2[31:0];
      a2_r   <= mant2[30:0];
      den2_r <= {1'b0, mant2} + 33'h0_8000_0000;
    end
  end

  // exp argument preparation
  assign tprod = 63'(d2_r) * 63'(decay_rate_r);
  assign v5    = pb4_r + 38'(pa4_r[47:16]);
  assign yprod = 63'(f5_r) * 63'(edist_pkg::LN2_Q32);

  always_comb begin
    tag5_nxt   = tag4_r;
    tag5_nxt.n = big4_r ? edist_pkg::N_FLUSH : 7'(v5[37:31]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r <= '0;
      tag4_r <= '0;
      tag5_r <= '0;
      tag6_r <= '0;
    end else if (en) begin
      tag3_r <= tag2_r;
      t3_r   <= tprod[62:16];
      tag4_r <= tag3_r;
      big4_r <= |t3_r[46:22];
      pa4_r  <= 48'(t3_r[15:0]) * 48'(edist_pkg::LOG2E_Q31);
      pb4_r  <= 38'(t3_r[21:16]) * 38'(edist_pkg::LOG2E_Q31);
      tag5_r <= tag5_nxt;
      f5_r   <= v5[30:0];
      tag6_r <= tag5_r;
      y6_r   <= yprod[62:31];
    end
  end

  // align with the divider
  always_comb begin
    xd_nxt.tag = tag6_r;
    xd_nxt.y   = y6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < edist_pkg::XDELAY; i++) xd_r[i] <= '0;
    end else if (en) begin
      xd_r[0] <= xd_nxt;
      for (int i = 1; i < edist_pkg::XDELAY; i++) xd_r[i] <= xd_r[i-1];
    end
  end

  assign xd_out = xd_r[edist_pkg::XDELAY-1];

  edist_div_pipe u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .num_i (a2_r),
    .den_i (den2_r),
    .quo_o (quo)
  );

  assign zprod = 64'(quo) * 64'(quo);

  always_ff @(posedge clk) begin
    if (en) begin
      zz_z_r  <= quo;
      zz_z2_r <= zprod[63:32];
    end
  end

  // series
  always_comb begin
    ser_in.tag = xd_out.tag;
    if (xd_out.tag.cmd == edist_pkg::CMD_QUANTILE) begin
      ser_in.op   = zz_z2_r;
      ser_in.term = {1'b0, zz_z_r};
      ser_in.sum  = {1'b0, zz_z_r};
    end else begin
      ser_in.op   = xd_out.y;
      ser_in.term = edist_pkg::ONE_Q32;
      ser_in.sum  = edist_pkg::ONE_Q32;
    end
  end

  assign ser_c[0] = ser_in;

  for (genvar j = 0; j < edist_pkg::SERIES_TERMS; j++) begin : g_series
    edist_series_step #(
      .STEP (j + 1)
    ) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ser_i (ser_c[j]),
      .ser_o (ser_c[j+1])
    );
  end

  assign ser_end = ser_c[edist_pkg::SERIES_TERMS];

  // scale exp result, finish log
  assign sh  = 6'(ser_end.tag.n) + 6'(edist_pkg::FRAC_BITS);
  assign rnd = 64'(ser_end.sum) + (64'd1 << (sh - 6'd1));

  always_comb begin
    if (ser_end.tag.n >= edist_pkg::N_LIMIT) begin
      e_nxt = '0;
    end else begin
      e_nxt = 17'(rnd >> sh);
    end
  end

  assign lnpos  = 38'(edist_pkg::QM_TOP - ser_end.tag.m) * 38'(edist_pkg::LN2_Q32);
  assign lqs    = $signed(lnpos) - $signed({4'b0, ser_end.sum, 1'b0});
  assign lq_nxt = lqs[37] ? 36'd0 : lqs[35:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bk_tag_r <= '0;
    end else if (en) begin
      bk_tag_r <= ser_end.tag;
      bk_e_r   <= e_nxt;
      bk_lq_r  <= lq_nxt;
    end
  end

  // shared multiplier: density scale or quantile length product
  assign mu_ln = bk_tag_r.cmd == edist_pkg::CMD_QUANTILE;
  assign ma    = mu_ln ? decay_length_r : decay_rate_r;
  assign mb    = mu_ln ? bk_lq_r[31:0] : 32'(bk_e_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_tag_r <= '0;
    end else if (en) begin
      mu_tag_r <= bk_tag_r;
      mu_e_r   <= bk_e_r;
      mu_lo_r  <= 63'(ma) * 63'(mb);
      mu_hi_r  <= 35'(decay_length_r) * 35'(bk_lq_r[35:32]);
    end
  end

  assign lo_rnd = mu_lo_r + 63'h0_8000_0000;
  assign qprod  = 37'(mu_hi_r) + 37'(lo_rnd[62:32]);
  assign qtotal = $signed({{6{lower_bound_r[31]}}, lower_bound_r}) + $signed({1'b0, qprod});
  assign fin_vld = mu_tag_r.valid;

  always_comb begin
    fin_res = '0;
    fin_sat = 1'b0;
    case (mu_tag_r.cmd)
      edist_pkg::CMD_DENSITY: begin
        if (!mu_tag_r.below) fin_res = mu_lo_r[47:16];
      end
      edist_pkg::CMD_CUMULATIVE: begin
        if (!mu_tag_r.below) fin_res = 32'(17'h1_0000 - mu_e_r);
      end
      edist_pkg::CMD_QUANTILE: begin
        if (qtotal > $signed(38'h0_7FFF_FFFF)) begin
          fin_res = 32'h7FFF_FFFF;
          fin_sat = 1'b1;
        end else begin
          fin_res = qtotal[31:0];
        end
      end
      default: ;
    endcase
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        out_res_r  <= skid_res_r;
        out_sat_r  <= skid_sat_r;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= fin_vld;
        out_res_r <= fin_res;
        out_sat_r <= fin_sat;
      end
    end else if (fin_vld && en) begin
      skid_vld_r <= 1'b1;
      skid_res_r <= fin_res;
      skid_sat_r <= fin_sat;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_result_value = out_res_r;
  assign out_saturated    = out_sat_r;

endmodule

/* src/edist_checker.sv */
// ----------------------------------------------------------------------------
// Exponential distribution evaluator checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "exponential_distribution_eval_core_assert.svh"

module edist_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic        out_saturated
);

  `EDIST_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped before transfer")
  `EDIST_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_result_value) && $stable(out_saturated), "result changed while stalled")
  `EDIST_ASSERT(a_sat_max, out_valid && out_saturated |-> out_result_value == 32'h7FFF_FFFF, "saturated result not at maximum")
  `EDIST_ASSERT_RST(a_reset_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind exponential_distribution_eval_core edist_checker u_edist_checker (.*);
